// ===== rtl/cwu_pkg.sv =====
package cwu_pkg;

    // Shared datapath width of the iterative unit
    localparam int WIDE_W = 128;

    // Field widths
    localparam int SEG_W      = 16;
    localparam int RATE_W     = 40;
    localparam int WIN_W      = 32;
    localparam int QLEN_W     = 24;
    localparam int TIME_W     = 63;
    localparam int SEQ_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Operand widths of the feedback arithmetic
    localparam int PS_W     = 40;   // 10^12 fits in 40 bits
    localparam int PKT_W    = 11;   // 1500 fits in 11 bits
    localparam int X_W      = WIN_W + PS_W;
    localparam int D_W      = 2 * RATE_W;
    localparam int RTTPKT_W = RATE_W + PKT_W;

    localparam logic [PS_W-1:0]  PS_PER_S  = 40'd1000000000000;
    localparam logic [PKT_W-1:0] PKT_BYTES = 11'd1500;

    localparam int REACT_FRAC_BITS_DEF = 16;

    // Register reset values
    localparam logic [SEG_W-1:0]  SEG_RST       = 16'd1500;
    localparam logic [RATE_W-1:0] LINK_RATE_RST = 40'd12500000000;
    localparam logic [RATE_W-1:0] BASE_RTT_RST  = 40'd8000000;
    localparam logic [WIN_W-1:0]  MIN_WIN_RST   = 32'd1500;
    localparam logic [WIN_W-1:0]  MAX_WIN_RST   = 32'hFFFF_FFFF;
    localparam logic [WIN_W-1:0]  INIT_WIN_RST  = 32'd15000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RTT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 3'd5;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_cmd;

endpackage

// ===== rtl/congestion_window_update.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    action, queue_len, rtt_sample, now_time,
//                                                 increase_flag, ack_number, highest_sent
// out       output     o_out_valid / i_out_stall  window, decreased
// cfg       input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// An ack beat runs through accept, window update and clamp, and result load.
// A feedback beat runs six operations, five when react saturates and the divide is
// skipped, through one shared shift-add / shift-subtract unit, one operand bit per
// cycle; the multiplier bit lengths and the divide steps set how long it runs.
// The input is stalled from acceptance until the result is loaded; the finished
// result sits in an output register, and the block waits there only while that
// register still holds an untaken beat.
// Reset is synchronous and active low and loads the register defaults; no clear sweep.
module congestion_window_update #(
    parameter int REACT_FRAC_BITS = cwu_pkg::REACT_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_we,
    input  logic [cwu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwu_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [cwu_pkg::QLEN_W-1:0]     i_queue_len,
    input  logic [cwu_pkg::RATE_W-1:0]     i_rtt_sample,
    input  logic [cwu_pkg::TIME_W-1:0]     i_now_time,
    input  logic                           i_increase_flag,
    input  logic [cwu_pkg::SEQ_W-1:0]      i_ack_number,
    input  logic [cwu_pkg::SEQ_W-1:0]      i_highest_sent,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cwu_pkg::WIN_W-1:0]      o_window,
    output logic                           o_decreased
);
    localparam int W       = cwu_pkg::WIDE_W;
    localparam int WIN_W   = cwu_pkg::WIN_W;
    localparam int REACT_W = REACT_FRAC_BITS + 1;
    localparam int RQ_W    = REACT_W + cwu_pkg::QLEN_W;
    localparam logic [REACT_W-1:0] REACT_ONE = REACT_W'(1) << REACT_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACK,
        S_MUL_LHS,
        S_MUL_X,
        S_MUL_D,
        S_REACT,
        S_REACT_LD,
        S_MUL_RQ,
        S_MUL_RHS,
        S_WAIT,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state r_after;

    // Configuration
    logic [cwu_pkg::SEG_W-1:0]  r_seg;
    logic [cwu_pkg::RATE_W-1:0] r_link_rate;
    logic [cwu_pkg::RATE_W-1:0] r_base_rtt;
    logic [WIN_W-1:0]           r_min_window;
    logic [WIN_W-1:0]           r_max_window;

    // Flow state
    logic [WIN_W-1:0]             r_cwnd;
    logic [cwu_pkg::TIME_W-1:0]   r_last_dec;
    logic [cwu_pkg::SEQ_W-1:0]    r_mark;

    // Captured beat
    logic                         r_act;
    logic [cwu_pkg::QLEN_W-1:0]   r_qlen;
    logic [cwu_pkg::RATE_W-1:0]   r_rtt;
    logic [cwu_pkg::TIME_W-1:0]   r_now;
    logic                         r_inc;
    logic [cwu_pkg::SEQ_W-1:0]    r_ack;
    logic [cwu_pkg::SEQ_W-1:0]    r_hsent;

    // Intermediate results
    logic [cwu_pkg::RTTPKT_W-1:0] r_lhs;
    logic [cwu_pkg::X_W-1:0]      r_x;
    logic [REACT_W-1:0]           r_react;
    logic                         r_dec;

    // Output register
    logic                         r_out_valid;
    logic [WIN_W-1:0]             r_out_window;
    logic                         r_out_dec;

    // Shared unit
    cwu_pkg::t_unit_cmd n_cmd;
    logic [W-1:0]       n_op_a;
    logic [W-1:0]       n_op_b;
    logic               w_unit_done;
    logic [W-1:0]       w_unit_res;

    logic                         n_accept;
    logic [cwu_pkg::D_W-1:0]      n_d;
    logic                         n_saturate;
    logic [cwu_pkg::TIME_W-1:0]   n_delta;
    logic [W-1:0]                 n_lhs_full;
    logic                         n_cut_now;
    logic [WIN_W-1:0]             n_cut_window;
    logic                         n_mark_hit;
    logic [WIN_W+1:0]             n_ack_sum;
    logic [WIN_W+1:0]             n_ack_lo;
    logic [WIN_W-1:0]             n_ack_window;
    logic                         n_out_free;

    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_out_free = !r_out_valid || !i_out_stall;

    // Feedback math: react saturates when cwnd*10^12 reaches base_rtt*link_rate
    always_comb begin
        n_d          = w_unit_res[cwu_pkg::D_W-1:0];
        n_saturate   = {{(cwu_pkg::D_W - cwu_pkg::X_W){1'b0}}, r_x} >= n_d;
        n_delta      = r_now - r_last_dec;
        n_lhs_full   = W'(r_lhs) << REACT_FRAC_BITS;
        n_cut_now    = n_lhs_full < w_unit_res;
        n_cut_window = (r_cwnd >= WIN_W'(r_seg)) ? (r_cwnd - WIN_W'(r_seg)) : '0;
    end

    // Ack math: grow by up to two segments, clamp to min then max
    always_comb begin
        n_mark_hit = r_ack >= r_mark;
        n_ack_sum  = (WIN_W + 2)'(r_cwnd)
                   + (r_inc ? (WIN_W + 2)'(r_seg) : '0)
                   + (n_mark_hit ? (WIN_W + 2)'(r_seg) : '0);
        n_ack_lo   = (n_ack_sum < (WIN_W + 2)'(r_min_window))
                   ? (WIN_W + 2)'(r_min_window) : n_ack_sum;
        n_ack_window = (n_ack_lo > (WIN_W + 2)'(r_max_window))
                     ? r_max_window : n_ack_lo[WIN_W-1:0];
    end

    // Operation issue
    always_comb begin
        n_cmd.start = 1'b0;
        n_cmd.op    = cwu_pkg::OP_MUL;
        n_op_a      = '0;
        n_op_b      = '0;
        case (r_state)
            S_MUL_LHS: begin
                n_cmd.start = 1'b1;
                n_op_a      = W'(r_rtt);
                n_op_b      = W'(cwu_pkg::PKT_BYTES);
            end
            S_MUL_X: begin
                n_cmd.start = 1'b1;
                n_op_a      = W'(cwu_pkg::PS_PER_S);
                n_op_b      = W'(r_cwnd);
            end
            S_MUL_D: begin
                n_cmd.start = 1'b1;
                n_op_a      = W'(r_link_rate);
                n_op_b      = W'(r_base_rtt);
            end
            S_REACT: begin
                n_cmd.start = !n_saturate;
                n_cmd.op    = cwu_pkg::OP_DIV;
                n_op_a      = W'(r_x);
                n_op_b      = W'(n_d);
            end
            S_MUL_RQ: begin
                n_cmd.start = 1'b1;
                n_op_a      = W'(r_react);
                n_op_b      = W'(r_qlen);
            end
            S_MUL_RHS: begin
                // Shorter operand drives the iteration count
                n_cmd.start = 1'b1;
                n_op_a      = W'(n_delta);
                n_op_b      = W'(w_unit_res[RQ_W-1:0]);
            end
            default: begin
                n_cmd.start = 1'b0;
            end
        endcase
    end

    cwu_iter_unit #(
        .FRAC_BITS (REACT_FRAC_BITS)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (n_cmd),
        .i_a      (n_op_a),
        .i_b      (n_op_b),
        .o_done   (w_unit_done),
        .o_result (w_unit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_after       <= S_IDLE;
            r_seg         <= cwu_pkg::SEG_RST;
            r_link_rate   <= cwu_pkg::LINK_RATE_RST;
            r_base_rtt    <= cwu_pkg::BASE_RTT_RST;
            r_min_window  <= cwu_pkg::MIN_WIN_RST;
            r_max_window  <= cwu_pkg::MAX_WIN_RST;
            r_cwnd        <= cwu_pkg::INIT_WIN_RST;
            r_last_dec    <= '0;
            r_mark        <= '0;
            r_dec         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Drop the output beat once taken, unless a new one loads in its place
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            // The user must write configuration only while idle; the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cwu_pkg::CFG_SEGMENT_SIZE:
                        r_seg <= i_cfg_data[cwu_pkg::SEG_W-1:0];
                    cwu_pkg::CFG_LINK_RATE:
                        r_link_rate <= i_cfg_data[cwu_pkg::RATE_W-1:0];
                    cwu_pkg::CFG_BASE_RTT:
                        r_base_rtt <= i_cfg_data[cwu_pkg::RATE_W-1:0];
                    cwu_pkg::CFG_MIN_WINDOW:
                        r_min_window <= i_cfg_data[WIN_W-1:0];
                    cwu_pkg::CFG_MAX_WINDOW:
                        r_max_window <= i_cfg_data[WIN_W-1:0];
                    cwu_pkg::CFG_INITIAL_WINDOW: begin
                        // Flow start: load the window at once
                        r_cwnd <= i_cfg_data[WIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_act   <= i_action;
                        r_qlen  <= i_queue_len;
                        r_rtt   <= i_rtt_sample;
                        r_now   <= i_now_time;
                        r_inc   <= i_increase_flag;
                        r_ack   <= i_ack_number;
                        r_hsent <= i_highest_sent;
                        r_state <= i_action ? S_MUL_LHS : S_ACK;
                    end
                end
                S_ACK: begin
                    r_cwnd  <= n_ack_window;
                    r_dec   <= 1'b0;
                    if (n_mark_hit) begin
                        r_mark <= r_hsent + cwu_pkg::SEQ_W'(1);
                    end
                    r_state <= S_EMIT;
                end
                S_MUL_LHS: begin
                    r_after <= S_MUL_X;
                    r_state <= S_WAIT;
                end
                S_MUL_X: begin
                    r_lhs   <= w_unit_res[cwu_pkg::RTTPKT_W-1:0];
                    r_after <= S_MUL_D;
                    r_state <= S_WAIT;
                end
                S_MUL_D: begin
                    r_x     <= w_unit_res[cwu_pkg::X_W-1:0];
                    r_after <= S_REACT;
                    r_state <= S_WAIT;
                end
                S_REACT: begin
                    if (n_saturate) begin
                        r_react <= REACT_ONE;
                        r_state <= S_MUL_RQ;
                    end else begin
                        r_after <= S_REACT_LD;
                        r_state <= S_WAIT;
                    end
                end
                S_REACT_LD: begin
                    r_react <= REACT_W'(w_unit_res[REACT_FRAC_BITS-1:0]);
                    r_state <= S_MUL_RQ;
                end
                S_MUL_RQ: begin
                    r_after <= S_MUL_RHS;
                    r_state <= S_WAIT;
                end
                S_MUL_RHS: begin
                    r_after <= S_DECIDE;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_unit_done) begin
                        r_state <= r_after;
                    end
                end
                S_DECIDE: begin
                    r_dec <= n_cut_now;
                    if (n_cut_now) begin
                        r_cwnd     <= n_cut_window;
                        r_last_dec <= r_now;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // Hold until the output register is free
                    if (n_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_window <= r_cwnd;
                        r_out_dec    <= r_dec;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_window    = r_out_window;
    assign o_decreased = r_out_dec;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> (r_state != S_IDLE))
        else $error("accepted beat did not start a sequence");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_unit_done |-> (r_state == S_WAIT))
        else $error("unit finished while the sequencer was not waiting");

    a_cut_only_feedback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !(r_dec && !r_act))
        else $error("ack beat flagged as a decrease");

    a_react_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_RQ) |-> (r_react <= REACT_ONE))
        else $error("reaction fraction above one");

endmodule

// ===== rtl/cwu_iter_unit.sv =====
// Shared shift-add multiplier and restoring fraction divider.
// One 129-bit add per cycle; the multiplier stops once its remaining bits are zero.
module cwu_iter_unit #(
    parameter int FRAC_BITS = cwu_pkg::REACT_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cwu_pkg::t_unit_cmd         i_cmd,
    input  logic [cwu_pkg::WIDE_W-1:0] i_a,
    input  logic [cwu_pkg::WIDE_W-1:0] i_b,
    output logic                       o_done,
    output logic [cwu_pkg::WIDE_W-1:0] o_result
);
    localparam int W     = cwu_pkg::WIDE_W;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic             r_busy;
    logic             r_done;
    cwu_pkg::t_op     r_op;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [CNT_W-1:0] r_cnt;

    logic             n_is_div;
    logic [W-1:0]     n_x;
    logic [W-1:0]     n_y;
    logic [W:0]       n_sum;

    // One adder: acc + a for multiply, (rem << 1) - den for divide
    always_comb begin
        n_is_div = (r_op == cwu_pkg::OP_DIV);
        n_x      = n_is_div ? {r_acc[W-2:0], 1'b0} : r_acc;
        n_y      = n_is_div ? ~r_a : r_a;
        n_sum    = {1'b0, n_x} + {1'b0, n_y} + {{W{1'b0}}, n_is_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= '0;
                if (i_cmd.op == cwu_pkg::OP_DIV) begin
                    r_acc <= i_a;
                    r_a   <= i_b;
                    r_b   <= '0;
                end else begin
                    r_acc <= '0;
                    r_a   <= i_a;
                    r_b   <= i_b;
                end
            end else if (r_busy) begin
                case (r_op)
                    cwu_pkg::OP_MUL: begin
                        if (r_b == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            if (r_b[0]) begin
                                r_acc <= n_sum[W-1:0];
                            end
                            r_a <= {r_a[W-2:0], 1'b0};
                            r_b <= {1'b0, r_b[W-1:1]};
                        end
                    end
                    cwu_pkg::OP_DIV: begin
                        if (r_cnt == CNT_W'(FRAC_BITS)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            // Carry out set means the shifted remainder covers the divisor
                            if (n_sum[W]) begin
                                r_acc <= n_sum[W-1:0];
                                r_b   <= {r_b[W-2:0], 1'b1};
                            end else begin
                                r_acc <= n_x;
                                r_b   <= {r_b[W-2:0], 1'b0};
                            end
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == cwu_pkg::OP_DIV) ? r_b : r_acc;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FRAC_BITS))
        else $error("divide step count past the fraction width");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("new operation issued while the unit is busy");

    a_done_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done raised without a running operation");

endmodule

// ===== test/congestion_window_update_test.sv =====
module congestion_window_update_test;

    localparam int REACT_BITS = cwu_pkg::REACT_FRAC_BITS_DEF;
    localparam int GROW_W     = cwu_pkg::WIN_W + 2;

    // Register indexes the block does not decode; writes to them must be ignored
    localparam logic [cwu_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [cwu_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // Receiver hold-off used to back the block up into its input
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic                       action;
        logic [cwu_pkg::QLEN_W-1:0] qlen;
        logic [cwu_pkg::RATE_W-1:0] rtt;
        logic [cwu_pkg::TIME_W-1:0] now;
        logic                       inc;
        logic [cwu_pkg::SEQ_W-1:0]  ack;
        logic [cwu_pkg::SEQ_W-1:0]  hsent;
    } t_beat;

    typedef struct {
        logic [cwu_pkg::WIN_W-1:0] window;
        logic                      decreased;
    } t_window_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [cwu_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [cwu_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_action = 1'b0;
    logic [cwu_pkg::QLEN_W-1:0]     i_queue_len = '0;
    logic [cwu_pkg::RATE_W-1:0]     i_rtt_sample = '0;
    logic [cwu_pkg::TIME_W-1:0]     i_now_time = '0;
    logic                           i_increase_flag = 1'b0;
    logic [cwu_pkg::SEQ_W-1:0]      i_ack_number = '0;
    logic [cwu_pkg::SEQ_W-1:0]      i_highest_sent = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [cwu_pkg::WIN_W-1:0]      o_window;
    logic                           o_decreased;

    congestion_window_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_queue_len     (i_queue_len),
        .i_rtt_sample    (i_rtt_sample),
        .i_now_time      (i_now_time),
        .i_increase_flag (i_increase_flag),
        .i_ack_number    (i_ack_number),
        .i_highest_sent  (i_highest_sent),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_window        (o_window),
        .o_decreased     (o_decreased)
    );

    initial forever #1 i_clk = ~i_clk;

    // Window state and register copies kept alongside the block
    logic [cwu_pkg::SEG_W-1:0]  seg_reg       = cwu_pkg::SEG_RST;
    logic [cwu_pkg::RATE_W-1:0] link_rate_reg = cwu_pkg::LINK_RATE_RST;
    logic [cwu_pkg::RATE_W-1:0] base_rtt_reg  = cwu_pkg::BASE_RTT_RST;
    logic [cwu_pkg::WIN_W-1:0]  min_win_reg   = cwu_pkg::MIN_WIN_RST;
    logic [cwu_pkg::WIN_W-1:0]  max_win_reg   = cwu_pkg::MAX_WIN_RST;
    logic [cwu_pkg::WIN_W-1:0]  cwnd          = cwu_pkg::INIT_WIN_RST;
    logic [cwu_pkg::TIME_W-1:0] last_cut_ps   = '0;
    logic [cwu_pkg::SEQ_W-1:0]  inc_mark      = '0;

    t_beat          beats_to_send[$];
    t_window_result window_due[$];
    t_beat          offered;

    // Traffic shape for well-formed random beats
    logic [cwu_pkg::TIME_W-1:0] clock_ps  = '0;
    logic [cwu_pkg::SEQ_W-1:0]  acked_seq = '0;

    int  errors        = 0;
    int  checked       = 0;
    int  fb_count      = 0;
    int  cut_count     = 0;
    int  ack_count     = 0;
    int  reg_writes    = 0;
    int  send_gap      = 0;
    int  stall_left    = 0;
    int  rx_hold_left  = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    bit  calm          = 1'b0;

    // Apply one accepted beat to the window state and return the result it must produce.
    function automatic t_window_result next_window(input t_beat b);
        t_window_result             r;
        logic [159:0]               scaled_cwnd;
        logic [159:0]               rate_product;
        logic [159:0]               frac;
        logic [159:0]               need;
        logic [159:0]               offer;
        logic [cwu_pkg::TIME_W-1:0] since_cut;
        logic [GROW_W-1:0]          grown;
        r.decreased = 1'b0;
        if (b.action) begin
            fb_count++;
            // Reaction fraction: cwnd over the bandwidth-delay product, capped at one
            scaled_cwnd  = 160'(cwnd) * 160'(cwu_pkg::PS_PER_S);
            rate_product = 160'(base_rtt_reg) * 160'(link_rate_reg);
            if (scaled_cwnd >= rate_product) begin
                frac = 160'(1) << REACT_BITS;
            end else begin
                frac = (scaled_cwnd << REACT_BITS) / rate_product;
            end
            // Elapsed time wraps modulo 2^63 when time runs backwards
            since_cut = b.now - last_cut_ps;
            need  = (160'(b.rtt) * 160'(cwu_pkg::PKT_BYTES)) << REACT_BITS;
            offer = frac * 160'(b.qlen) * 160'(since_cut);
            if (need < offer) begin
                // Floor at zero on a cut, no min clamp
                cwnd        = (cwnd >= cwu_pkg::WIN_W'(seg_reg))
                            ? cwnd - cwu_pkg::WIN_W'(seg_reg) : '0;
                last_cut_ps = b.now;
                r.decreased = 1'b1;
                cut_count++;
            end
        end else begin
            ack_count++;
            grown = GROW_W'(cwnd);
            if (b.inc) begin
                grown = grown + GROW_W'(seg_reg);
            end
            if (b.ack >= inc_mark) begin
                grown    = grown + GROW_W'(seg_reg);
                inc_mark = b.hsent + cwu_pkg::SEQ_W'(1);
            end
            // Min first, then max: max wins when the two cross
            if (grown < GROW_W'(min_win_reg)) begin
                grown = GROW_W'(min_win_reg);
            end
            if (grown > GROW_W'(max_win_reg)) begin
                grown = GROW_W'(max_win_reg);
            end
            cwnd = grown[cwu_pkg::WIN_W-1:0];
        end
        r.window = cwnd;
        return r;
    endfunction

    // Random value of random bit length, so small and large magnitudes both show up
    function automatic logic [63:0] rand_span(input int w);
        int          n;
        logic [63:0] v;
        n = $urandom_range(0, w);
        v = {$urandom, $urandom};
        return (n == 0) ? 64'd0 : (v & ((64'd1 << n) - 64'd1));
    endfunction

    function automatic t_beat random_beat();
        t_beat       b;
        int          pick;
        logic [63:0] v;
        pick = $urandom_range(0, 19);
        b.action = 1'b0;
        v        = rand_span(cwu_pkg::QLEN_W);
        b.qlen   = v[cwu_pkg::QLEN_W-1:0];
        v        = rand_span(cwu_pkg::RATE_W);
        b.rtt    = v[cwu_pkg::RATE_W-1:0];
        b.now    = clock_ps;
        b.inc    = 1'($urandom_range(0, 1));
        b.ack    = acked_seq;
        b.hsent  = acked_seq;
        if (pick < 9) begin
            // Cumulative ack moving forward, highest sent ahead of it
            v         = rand_span(16);
            acked_seq = acked_seq + v[cwu_pkg::SEQ_W-1:0];
            b.ack     = acked_seq;
            v         = rand_span(20);
            b.hsent   = acked_seq + v[cwu_pkg::SEQ_W-1:0];
        end else if (pick < 18) begin
            // Feedback with time moving forward
            v        = rand_span(36);
            clock_ps = clock_ps + v[cwu_pkg::TIME_W-1:0];
            b.action = 1'b1;
            b.now    = clock_ps;
        end else begin
            // Noise: every field uniform over its full width
            b.action = 1'($urandom_range(0, 1));
            b.qlen   = cwu_pkg::QLEN_W'($urandom);
            v        = {$urandom, $urandom};
            b.rtt    = v[cwu_pkg::RATE_W-1:0];
            v        = {$urandom, $urandom};
            b.now    = v[cwu_pkg::TIME_W-1:0];
            b.ack    = $urandom;
            b.hsent  = $urandom;
        end
        return b;
    endfunction

    task automatic send(input logic action, input logic [cwu_pkg::QLEN_W-1:0] qlen,
                        input logic [cwu_pkg::RATE_W-1:0] rtt,
                        input logic [cwu_pkg::TIME_W-1:0] now,
                        input logic inc, input logic [cwu_pkg::SEQ_W-1:0] ack,
                        input logic [cwu_pkg::SEQ_W-1:0] hsent);
        t_beat b;
        b.action = action;
        b.qlen   = qlen;
        b.rtt    = rtt;
        b.now    = now;
        b.inc    = inc;
        b.ack    = ack;
        b.hsent  = hsent;
        beats_to_send.push_back(b);
    endtask

    // Hold until every queued beat is taken and every result has come back
    task automatic wait_quiet();
        while (beats_to_send.size() != 0 || i_in_valid || window_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // One register write; only called with nothing in flight
    task automatic write_reg(input logic [cwu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cwu_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        reg_writes++;
        case (idx)
            cwu_pkg::CFG_SEGMENT_SIZE:   seg_reg       = data[cwu_pkg::SEG_W-1:0];
            cwu_pkg::CFG_LINK_RATE:      link_rate_reg = data[cwu_pkg::RATE_W-1:0];
            cwu_pkg::CFG_BASE_RTT:       base_rtt_reg  = data[cwu_pkg::RATE_W-1:0];
            cwu_pkg::CFG_MIN_WINDOW:     min_win_reg   = data[cwu_pkg::WIN_W-1:0];
            cwu_pkg::CFG_MAX_WINDOW:     max_win_reg   = data[cwu_pkg::WIN_W-1:0];
            cwu_pkg::CFG_INITIAL_WINDOW: cwnd          = data[cwu_pkg::WIN_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic shuffle_regs();
        logic [63:0] v;
        v = rand_span(cwu_pkg::SEG_W);
        write_reg(cwu_pkg::CFG_SEGMENT_SIZE, (v == 0) ? 40'd1 : v[cwu_pkg::CFG_DATA_W-1:0]);
        v = rand_span(cwu_pkg::RATE_W);
        write_reg(cwu_pkg::CFG_LINK_RATE, (v == 0) ? 40'd1 : v[cwu_pkg::CFG_DATA_W-1:0]);
        v = rand_span(cwu_pkg::RATE_W);
        write_reg(cwu_pkg::CFG_BASE_RTT, (v == 0) ? 40'd1 : v[cwu_pkg::CFG_DATA_W-1:0]);
        v = rand_span(cwu_pkg::WIN_W);
        write_reg(cwu_pkg::CFG_MIN_WINDOW, v[cwu_pkg::CFG_DATA_W-1:0]);
        v = rand_span(cwu_pkg::WIN_W);
        write_reg(cwu_pkg::CFG_MAX_WINDOW, v[cwu_pkg::CFG_DATA_W-1:0]);
        v = rand_span(cwu_pkg::WIN_W);
        write_reg(cwu_pkg::CFG_INITIAL_WINDOW, v[cwu_pkg::CFG_DATA_W-1:0]);
    endtask

    // Driver: predict on acceptance, then offer the next beat or idle for a burst.
    // Valid gets at most one assignment per edge and stays up while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                window_due.push_back(next_window(offered));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    // Start an idle burst, this one included
                    send_gap = $urandom_range(0, 8);
                    i_in_valid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    offered = beats_to_send.pop_front();
                    i_action        <= offered.action;
                    i_queue_len     <= offered.qlen;
                    i_rtt_sample    <= offered.rtt;
                    i_now_time      <= offered.now;
                    i_increase_flag <= offered.inc;
                    i_ack_number    <= offered.ack;
                    i_highest_sent  <= offered.hsent;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction, then pick the stall
    always @(posedge i_clk) begin
        t_window_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                checked++;
                if (window_due.size() == 0) begin
                    $error("result beat with nothing pending: window %0d decreased %0d",
                           o_window, o_decreased);
                    errors++;
                end else begin
                    want = window_due.pop_front();
                    if (o_window !== want.window) begin
                        $error("window: expected %0d, got %0d", want.window, o_window);
                        errors++;
                    end
                    if (o_decreased !== want.decreased) begin
                        $error("decreased: expected %0d, got %0d", want.decreased, o_decreased);
                        errors++;
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_requests != hold_served) begin
                // Long hold-off: let the block fill and push back on its input
                hold_served++;
                rx_hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: mark logic, mark wrap, zero queue, backward time, field extremes
        send(1'b0, '0, '0, '0, 1'b0, 32'd0, 32'd100);
        send(1'b0, '0, '0, '0, 1'b1, 32'd50, 32'd200);
        send(1'b0, '0, '0, '0, 1'b1, '1, '1);
        send(1'b1, '0, 40'd1, 63'd1000000000, 1'b0, '0, '0);
        send(1'b1, '1, '0, '1, 1'b0, '0, '0);
        send(1'b1, '1, 40'd5, '0, 1'b1, '1, '1);
        send(1'b1, 24'd1, '1, 63'd1, 1'b0, '0, '0);
        send(1'b1, '1, '1, '1, 1'b1, '1, '1);
        send(1'b0, '1, '1, '1, 1'b1, '1, '0);
        wait_quiet();

        // Largest step, react saturated, crossed clamps: cut twice down to zero,
        // then a zero window gives zero react, then the ack lands on max_window
        write_reg(cwu_pkg::CFG_SEGMENT_SIZE, 40'd65535);
        write_reg(cwu_pkg::CFG_LINK_RATE, 40'd1);
        write_reg(cwu_pkg::CFG_BASE_RTT, 40'd1);
        write_reg(cwu_pkg::CFG_MIN_WINDOW, 40'd100000);
        write_reg(cwu_pkg::CFG_MAX_WINDOW, 40'd50000);
        write_reg(cwu_pkg::CFG_INITIAL_WINDOW, 40'd70000);
        send(1'b1, 24'd1, '0, 63'd5, 1'b0, '0, '0);
        send(1'b1, 24'd1, '0, 63'd9, 1'b0, '0, '0);
        send(1'b1, '1, '0, '1, 1'b0, '0, '0);
        send(1'b0, '0, '0, '0, 1'b1, '1, 32'd7);
        wait_quiet();

        // Smallest step, widest rates, full window: ack growth past 32 bits;
        // spare indexes must not disturb anything
        write_reg(cwu_pkg::CFG_SEGMENT_SIZE, 40'd1);
        write_reg(cwu_pkg::CFG_LINK_RATE, '1);
        write_reg(cwu_pkg::CFG_BASE_RTT, '1);
        write_reg(cwu_pkg::CFG_MIN_WINDOW, 40'd0);
        write_reg(cwu_pkg::CFG_MAX_WINDOW, 40'hFF_FFFF_FFFF);
        write_reg(cwu_pkg::CFG_INITIAL_WINDOW, 40'hFF_FFFF_FFFF);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, 40'd12345);
        send(1'b0, '0, '0, '0, 1'b1, '1, '1);
        send(1'b1, '1, '1, '1, 1'b0, '0, '0);
        send(1'b1, '1, 40'd1, 63'd3, 1'b0, '0, '0);
        wait_quiet();

        // Zero base round trip: the rate product vanishes and react saturates
        write_reg(cwu_pkg::CFG_BASE_RTT, 40'd0);
        send(1'b1, 24'd100, 40'd1000, 63'd4000000000, 1'b0, '0, '0);
        send(1'b1, 24'd0, 40'd0, 63'd8000000000, 1'b0, '0, '0);
        wait_quiet();

        // Random phases, each under its own register set
        for (int phase = 0; phase < 8; phase++) begin
            shuffle_regs();
            if (phase == 2) begin
                hold_requests++;
            end
            for (int k = 0; k < 195; k++) begin
                beats_to_send.push_back(random_beat());
            end
            wait_quiet();
        end

        // Last stretch: defaults back, no idling on either side
        calm = 1'b1;
        write_reg(cwu_pkg::CFG_SEGMENT_SIZE, cwu_pkg::CFG_DATA_W'(cwu_pkg::SEG_RST));
        write_reg(cwu_pkg::CFG_LINK_RATE, cwu_pkg::CFG_DATA_W'(cwu_pkg::LINK_RATE_RST));
        write_reg(cwu_pkg::CFG_BASE_RTT, cwu_pkg::CFG_DATA_W'(cwu_pkg::BASE_RTT_RST));
        write_reg(cwu_pkg::CFG_MIN_WINDOW, cwu_pkg::CFG_DATA_W'(cwu_pkg::MIN_WIN_RST));
        write_reg(cwu_pkg::CFG_MAX_WINDOW, cwu_pkg::CFG_DATA_W'(cwu_pkg::MAX_WIN_RST));
        write_reg(cwu_pkg::CFG_INITIAL_WINDOW, cwu_pkg::CFG_DATA_W'(cwu_pkg::INIT_WIN_RST));
        for (int k = 0; k < 80; k++) begin
            beats_to_send.push_back(random_beat());
        end
        wait_quiet();

        // Catch any stray result after the last expected one
        repeat (250) @(posedge i_clk);

        if (window_due.size() != 0) begin
            $error("%0d results never arrived", window_due.size());
            errors++;
        end
        $display("Covered %0d beats: %0d acks, %0d feedback of which %0d cut the window",
                 checked, ack_count, fb_count, cut_count);
        $display("Register writes: %0d across 13 register settings, one long receiver hold-off",
                 reg_writes);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Timeout well beyond the slowest legal run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
